/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
// Both macros expect a signal named clk, and SOMR_ASSERT also one named rst, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SOMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, including those during reset.
`define SOMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/somr_pkg.sv */
// ----------------------------------------------------------------------------
// somr_pkg
// Shared widths and defaults for the spiral order matrix reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package somr_pkg;

  // Default matrix capacity and stored element width.
  localparam int MAX_SIDE_DEF      = 8;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int VALUE_W = 32;
  localparam int COORD_W = 3;
  localparam int SIZE_W  = 4;

  // Side length after reset.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

endpackage

`default_nettype wire

/* hdl/spiral_order_matrix_reorder_top.sv */
// ----------------------------------------------------------------------------
// spiral_order_matrix_reorder_top
// Loads a square matrix in row-major order and replays it in clockwise spiral
// order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / element_value) takes one element per
//   request, row-major. Output channel (out_valid / out_ready) gives one
//   request per element with out_value, out_row, out_column and run_end,
//   which marks the last element of a spiral.
//   matrix_size_we / matrix_size set the side length (values above MAX_SIDE
//   act as MAX_SIDE, zero swallows inputs with no output) and restart the
//   load at the first element. Write it only while the block is idle.
// Timing:
//   Elements load one per cycle while in_ready is high. Once the last
//   element of a matrix is accepted, each spiral element is read from the
//   element memory into a read register and then moved to the output
//   register, one per cycle while out_ready is high, paced by the single
//   read port of that memory. in_ready is low while the spiral addresses
//   are read; loading the next matrix overlaps draining the last outputs.
// Reset and stalls:
//   Reset clears the load position and pipeline and sets the side to 8; the
//   memory is not cleared. When out_ready is low while out_valid is high, the
//   output and one read result are held and the spiral walk pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_order_matrix_reorder_top #(
  parameter int MAX_SIDE      = somr_pkg::MAX_SIDE_DEF,
  parameter int ELEMENT_WIDTH = somr_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               matrix_size_we,
  input  wire logic [somr_pkg::SIZE_W-1:0]        matrix_size,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [somr_pkg::VALUE_W-1:0]       element_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [somr_pkg::VALUE_W-1:0]            out_value,
  output logic [somr_pkg::COORD_W-1:0]            out_row,
  output logic [somr_pkg::COORD_W-1:0]            out_column,
  output logic                                    run_end
);

  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (ELEMENT_WIDTH < somr_pkg::VALUE_W) ? ELEMENT_WIDTH
                                                              : somr_pkg::VALUE_W;
  localparam logic [AW-1:0] SIDE_A = AW'(MAX_SIDE);
  localparam logic [somr_pkg::SIZE_W-1:0] SIDE_MAX = somr_pkg::SIZE_W'(MAX_SIDE);

  // Walk directions.
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Element memory, one word per matrix position at row*MAX_SIDE+column.
  logic [SW-1:0] mem [DEPTH];

  logic [somr_pkg::SIZE_W-1:0] size_reg;
  logic [somr_pkg::SIZE_W-1:0] side_n;
  logic [IW-1:0]               side_last;

  logic [IW-1:0] load_row, load_col;
  logic          in_take, load_done;
  logic [AW-1:0] wr_addr;

  logic          emitting;
  logic [IW-1:0] top, bottom, row, col;
  logic [1:0]    dir;
  logic [IW-1:0] top_next, bottom_next, row_next, col_next;
  logic [1:0]    dir_next;
  logic          ring_done, ring_last, single, is_last;
  logic [IW:0]   top_p1;

  logic          rd_en, rd_valid, move;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic [IW-1:0] rd_row, rd_col;
  logic          rd_last;

  // Side length actually in use.
  always_comb begin
    side_n    = (size_reg > SIDE_MAX) ? SIDE_MAX : size_reg;
    side_last = IW'(side_n - somr_pkg::SIZE_W'(1));
  end

  // Load side: row-major write position.
  assign in_ready  = !emitting;
  assign in_take   = in_valid && in_ready && (side_n != '0);
  assign load_done = (load_col == side_last) && (load_row == side_last);
  assign wr_addr   = AW'(load_row) * SIDE_A + AW'(load_col);

  always_ff @(posedge clk) begin
    if (in_take) begin
      mem[wr_addr] <= element_value[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= somr_pkg::SIZE_RESET;
      load_row <= '0;
      load_col <= '0;
    end else if (matrix_size_we) begin
      size_reg <= matrix_size;
      load_row <= '0;
      load_col <= '0;
    end else if (in_take) begin
      if (load_col == side_last) begin
        load_col <= '0;
        load_row <= load_done ? '0 : load_row + IW'(1);
      end else begin
        load_col <= load_col + IW'(1);
      end
    end
  end

  // Next spiral position from the current one and the ring bounds.
  always_comb begin
    top_p1      = {1'b0, top} + (IW+1)'(1);
    single      = (top == bottom);
    ring_last   = ({1'b0, bottom} == top_p1);
    ring_done   = 1'b0;
    top_next    = top;
    bottom_next = bottom;
    row_next    = row;
    col_next    = col;
    dir_next    = dir;
    unique case (dir)
      DIR_RIGHT: begin
        if (col == bottom) begin
          dir_next = DIR_DOWN;
          row_next = row + IW'(1);
        end else begin
          col_next = col + IW'(1);
        end
      end
      DIR_DOWN: begin
        if (row == bottom) begin
          dir_next = DIR_LEFT;
          col_next = col - IW'(1);
        end else begin
          row_next = row + IW'(1);
        end
      end
      DIR_LEFT: begin
        if (col == top) begin
          if (ring_last) begin
            ring_done = 1'b1;
          end else begin
            dir_next = DIR_UP;
            row_next = row - IW'(1);
          end
        end else begin
          col_next = col - IW'(1);
        end
      end
      DIR_UP: begin
        if ({1'b0, row} == top_p1) begin
          ring_done = 1'b1;
        end else begin
          row_next = row - IW'(1);
        end
      end
      default: begin
        ring_done = 1'b1;
      end
    endcase
    if (ring_done) begin
      top_next    = top + IW'(1);
      bottom_next = bottom - IW'(1);
      row_next    = top + IW'(1);
      col_next    = top + IW'(1);
      dir_next    = DIR_RIGHT;
    end
    is_last = single || (ring_done && ring_last);
  end

  // Read issue: while the walk is active, a new read goes out when the read result slot is free or being emptied.
  assign move    = rd_valid && (!out_valid || out_ready);
  assign rd_en   = emitting && (!rd_valid || move);
  assign rd_addr = AW'(row) * SIDE_A + AW'(col);

  // Spiral walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
    end else if (in_take && load_done) begin
      emitting <= 1'b1;
    end else if (rd_en && is_last) begin
      emitting <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && load_done) begin
      top    <= '0;
      bottom <= side_last;
      row    <= '0;
      col    <= '0;
      dir    <= DIR_RIGHT;
    end else if (rd_en) begin
      top    <= top_next;
      bottom <= bottom_next;
      row    <= row_next;
      col    <= col_next;
      dir    <= dir_next;
    end
  end

  // Registered memory read with its position and end mark.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_row  <= row;
      rd_col  <= col;
      rd_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= 1'b1;
    end else if (move) begin
      rd_valid <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_value  <= somr_pkg::VALUE_W'(rd_data);
      out_row    <= somr_pkg::COORD_W'(rd_row);
      out_column <= somr_pkg::COORD_W'(rd_col);
      run_end    <= rd_last;
    end
  end

endmodule

`default_nettype wire

/* hdl/somr_checker.sv */
// ----------------------------------------------------------------------------
// somr_checker
// Port-level checks for the spiral order matrix reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module somr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          matrix_size_we,
  input wire logic [somr_pkg::SIZE_W-1:0]   matrix_size,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [somr_pkg::VALUE_W-1:0]  element_value,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [somr_pkg::VALUE_W-1:0]  out_value,
  input wire logic [somr_pkg::COORD_W-1:0]  out_row,
  input wire logic [somr_pkg::COORD_W-1:0]  out_column,
  input wire logic                          run_end
);

  // Stall condition and the whole output payload as one word.
  logic                                            out_stall;
  logic [somr_pkg::VALUE_W+2*somr_pkg::COORD_W:0]  out_word;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_value, out_row, out_column, run_end};

  // A stalled output request stays valid and keeps its whole payload.
  `SOMR_ASSERT(a_out_hold, out_stall |=> out_valid, "output request dropped while stalled")
  `SOMR_ASSERT(a_out_stable, out_stall |=> $stable(out_word), "payload changed while stalled")

  // Reset empties the output register.
  `SOMR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

  // The input side only closes after a request was taken.
  `SOMR_ASSERT(a_ready_fall, $fell(in_ready) |-> $past(in_valid), "in_ready fell with no request")

endmodule

bind spiral_order_matrix_reorder_top somr_checker u_somr_checker (.*);

`default_nettype wire
